/* rtl/mm4_pkg.sv */
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int ROW_W     = 2;

  // Row tag plus DIM elements, padded up to whole bytes.
  localparam int PAYLOAD_W = ROW_W + DIM * ELEM_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int PAD_W     = TDATA_W - PAYLOAD_W;

  // One product, a sum of two, and the full sum of DIM products.
  localparam int PROD_W = 2 * ELEM_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [ELEM_W-1:0] ONE_Q   = ELEM_W'(1) << FRAC_BITS;
  localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_t;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DIM-1:0] row_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ROW_W-1:0] row;
    row_t             elems;
  } item_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

/* rtl/matrix_4x4_multiply.sv */
// Row-by-row product of a row of A with a stored 4x4 matrix B, signed Q16.16.
// Input requests arrive on the in_ stream. in_tuser is the command: a load
// writes in_tdata's elements into row row_index of B and gives no result; a
// multiply forms one row of A*B, tagged with row_index, on the out_ stream.
// Each output element is the exact sum of four 64-bit products, shifted right
// arithmetically by 16 and saturated to the signed 32-bit range.
// An accepted multiply is registered in the two-entry request queue, is taken
// into the product stage, then the pair-sum stage, then the final sum, shift
// and saturate stage into the output register, which drives out_tvalid. One
// request is taken per cycle while the output is not stalled; the 16 parallel
// multipliers set that rate.
// Loads and multiplies take effect in arrival order, so a multiply sees every
// load that came before it.
// Reset sets B to the identity matrix and empties the queue and pipeline.
// While out_tready is low with a result waiting, the pipeline holds; the queue
// still takes up to two requests before in_tready drops.
module matrix_4x4_multiply (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: row_index, elem_0, elem_1, elem_2, elem_3, zero padding.
  input  logic [mm4_pkg::TDATA_W-1:0] in_tdata,
  // Fields from bit 0: command.
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // Fields from bit 0: result_row, out_0, out_1, out_2, out_3, zero padding.
  output logic [mm4_pkg::TDATA_W-1:0] out_tdata
);

  mm4_pkg::item_t                in_item;
  mm4_pkg::queue_head_t          head;
  logic                          pop;
  logic [mm4_pkg::ROW_W-1:0]     res_row;
  mm4_pkg::row_t                 res_elems;

  assign in_item.cmd   = mm4_pkg::cmd_t'(in_tuser);
  assign in_item.row   = in_tdata[mm4_pkg::ROW_W-1:0];
  assign in_item.elems = in_tdata[mm4_pkg::PAYLOAD_W-1:mm4_pkg::ROW_W];

  mm4_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  mm4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_row   (res_row),
    .res_elems (res_elems)
  );

  assign out_tdata = {{mm4_pkg::PAD_W{1'b0}}, res_elems, res_row};

endmodule

/* rtl/mm4_front.sv */
module mm4_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mm4_pkg::item_t      in_item,
  output mm4_pkg::queue_head_t head,
  input  logic                pop
);

  localparam int DEPTH = 2;

  mm4_pkg::item_t mem_r [DEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           do_pop;

  assign in_ready   = (count_r != 2'(DEPTH));
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

/* rtl/mm4_back.sv */
module mm4_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mm4_pkg::queue_head_t          head,
  output logic                          pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [mm4_pkg::ROW_W-1:0]     res_row,
  output mm4_pkg::row_t                 res_elems
);

  localparam int DIM = mm4_pkg::DIM;
  localparam int ROW_W = mm4_pkg::ROW_W;
  localparam int PROD_W = mm4_pkg::PROD_W;
  localparam int PAIR_W = mm4_pkg::PAIR_W;
  localparam int SUM_W = mm4_pkg::SUM_W;
  localparam int ELEM_W = mm4_pkg::ELEM_W;

  mm4_pkg::row_t b_r [DIM];

  logic                     adv;
  logic                     mul_go;
  logic                     load_go;

  logic                     s1_valid_r;
  logic [ROW_W-1:0]         s1_row_r;
  logic signed [PROD_W-1:0] prod_r [DIM][DIM];

  logic                     s2_valid_r;
  logic [ROW_W-1:0]         s2_row_r;
  logic signed [PAIR_W-1:0] pair_lo_r [DIM];
  logic signed [PAIR_W-1:0] pair_hi_r [DIM];

  logic                     out_valid_r;
  logic [ROW_W-1:0]         out_row_r;
  mm4_pkg::row_t            out_elems_r;
  mm4_pkg::row_t            sat_elems;

  // The whole pipeline moves together; it holds only when the result register is full
  // and the receiver is stalling.
  assign adv     = !out_valid_r || res_ready;
  assign pop     = head.valid && adv;
  assign mul_go  = pop && (head.item.cmd == mm4_pkg::CMD_MUL);
  assign load_go = pop && (head.item.cmd == mm4_pkg::CMD_LOAD);

  // Row loads take effect after the products of any earlier multiply were captured.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          b_r[r][c] <= (r == c) ? mm4_pkg::ONE_Q : '0;
        end
      end
    end else if (load_go) begin
      b_r[head.item.row] <= head.item.elems;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIM; k++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_r[k][c] <= PROD_W'(head.item.elems[k]) * PROD_W'(b_r[k][c]);
        end
      end
      s1_row_r <= head.item.row;
      for (int c = 0; c < DIM; c++) begin
        pair_lo_r[c] <= PAIR_W'(prod_r[0][c]) + PAIR_W'(prod_r[1][c]);
        pair_hi_r[c] <= PAIR_W'(prod_r[2][c]) + PAIR_W'(prod_r[3][c]);
      end
      s2_row_r    <= s1_row_r;
      out_elems_r <= sat_elems;
      out_row_r   <= s2_row_r;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] shifted;
    logic [SUM_W-ELEM_W:0]   top;
    for (int c = 0; c < DIM; c++) begin
      total   = SUM_W'(pair_lo_r[c]) + SUM_W'(pair_hi_r[c]);
      shifted = total >>> mm4_pkg::FRAC_BITS;
      top     = shifted[SUM_W-1:ELEM_W-1];
      if ((top == '0) || (top == '1)) begin
        sat_elems[c] = shifted[ELEM_W-1:0];
      end else if (shifted[SUM_W-1]) begin
        sat_elems[c] = mm4_pkg::SAT_MIN;
      end else begin
        sat_elems[c] = mm4_pkg::SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= mul_go;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res_row   = out_row_r;
  assign res_elems = out_elems_r;

endmodule

/* sim/matrix_4x4_multiply_tb.sv */
`timescale 1ns / 100ps

module matrix_4x4_multiply_tb;

  localparam int DIM       = mm4_pkg::DIM;
  localparam int FRAC_BITS = mm4_pkg::FRAC_BITS;
  localparam int ELEM_W    = mm4_pkg::ELEM_W;
  localparam int ROW_W     = mm4_pkg::ROW_W;
  localparam int SUM_W     = mm4_pkg::SUM_W;
  localparam int TDATA_W   = mm4_pkg::TDATA_W;
  localparam int PAD_W     = mm4_pkg::PAD_W;

  typedef mm4_pkg::elem_t elem_t;
  typedef mm4_pkg::row_t  row_t;
  typedef mm4_pkg::cmd_t  cmd_t;

  localparam elem_t SAT_MAX  = mm4_pkg::SAT_MAX;
  localparam elem_t SAT_MIN  = mm4_pkg::SAT_MIN;
  localparam elem_t ONE_Q    = mm4_pkg::ONE_Q;
  localparam cmd_t  CMD_LOAD = mm4_pkg::CMD_LOAD;
  localparam cmd_t  CMD_MUL  = mm4_pkg::CMD_MUL;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    row_t             vals;
  } product_row_t;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(64'sd2147483648);

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;

  row_t         b_rows [DIM];
  product_row_t pending_products [$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  int           stall_cycles   = 0;

  matrix_4x4_multiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Each output element is the exact 66-bit sum of four products, floored by
  // the arithmetic shift and then clamped to the signed 32-bit range.
  function automatic row_t row_times_b(row_t a);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] ax;
    logic signed [SUM_W-1:0] bx;
    row_t                    r;
    for (int c = 0; c < DIM; c++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        ax  = $signed(a[k]);
        bx  = $signed(b_rows[k][c]);
        acc = acc + ax * bx;
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SUM_HI) begin
        r[c] = SAT_MAX;
      end else if (shifted < SUM_LO) begin
        r[c] = SAT_MIN;
      end else begin
        r[c] = shifted[ELEM_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic row_t make_row(elem_t e0, elem_t e1, elem_t e2, elem_t e3);
    row_t r;
    r[0] = e0;
    r[1] = e1;
    r[2] = e2;
    r[3] = e3;
    return r;
  endfunction

  function automatic elem_t random_elem();
    case ($urandom_range(9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return '0;
      3: return ONE_Q;
      4, 5, 6: return elem_t'($urandom_range(32'h0010_0000)) - elem_t'(32'h0008_0000);
      default: return elem_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Called on a rising edge; leaves the request on the bus after acceptance so
  // that back-to-back requests never toggle in_tvalid within one step.
  task automatic send_request(cmd_t cmd, logic [ROW_W-1:0] row, row_t elems);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{PAD_W{1'b0}}, elems, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      b_rows[row] = elems;
    end else begin
      pending_products.push_back('{row: row, vals: row_times_b(elems)});
    end
  endtask

  task automatic check_result(logic [TDATA_W-1:0] data);
    product_row_t want;
    elem_t        got;
    if (pending_products.size() == 0) begin
      report_mismatch($sformatf("result with none pending, tdata %h", data));
    end else begin
      want = pending_products.pop_front();
      if (data[ROW_W-1:0] !== want.row) begin
        report_mismatch($sformatf("result_row expected %0d got %0d",
                                  want.row, data[ROW_W-1:0]));
      end
      for (int c = 0; c < DIM; c++) begin
        got = data[ROW_W + c*ELEM_W +: ELEM_W];
        if (got !== want.vals[c]) begin
          report_mismatch($sformatf("row %0d out_%0d expected %h got %h",
                                    want.row, c, want.vals[c], got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
      if (stall_cycles > 0) begin
        stall_cycles = stall_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // B is the identity after reset, so every product row equals its input row.
  task automatic test_identity_after_reset();
    send_request(CMD_MUL, 2'd0, make_row(SAT_MAX, SAT_MIN, '0, -elem_t'(1)));
    send_request(CMD_MUL, 2'd3, make_row(ONE_Q, -ONE_Q, elem_t'(1), elem_t'(32'h0001_8000)));
  endtask

  task automatic test_directed_extremes();
    for (int r = 0; r < DIM; r++) begin
      send_request(CMD_LOAD, ROW_W'(r), make_row(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    end
    // The sum of four products of (-2^31)*(-2^31) overflows 64 bits and must saturate high.
    send_request(CMD_MUL, 2'd1, make_row(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    send_request(CMD_MUL, 2'd2, make_row(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
    send_request(CMD_MUL, 2'd3, make_row(elem_t'(1), '0, '0, '0));
    send_request(CMD_MUL, 2'd0, make_row(-elem_t'(1), '0, '0, '0));
    // A sum that lands exactly on the top of the range, then one past it.
    send_request(CMD_LOAD, 2'd0, make_row(ONE_Q, '0, -elem_t'(1), ONE_Q));
    send_request(CMD_LOAD, 2'd1, make_row(ONE_Q, ONE_Q, '0, -ONE_Q));
    send_request(CMD_MUL, 2'd0, make_row(SAT_MAX, '0, '0, '0));
    send_request(CMD_MUL, 2'd1, make_row(SAT_MAX, elem_t'(1), '0, '0));
    send_request(CMD_MUL, 2'd2, make_row(SAT_MIN, -elem_t'(1), '0, '0));
    // Small negative sums round toward minus infinity.
    send_request(CMD_LOAD, 2'd2, make_row(elem_t'(3), -elem_t'(5), ONE_Q, '0));
    send_request(CMD_LOAD, 2'd3, make_row('0, elem_t'(32'h0000_8000), '0, ONE_Q));
    send_request(CMD_MUL, 2'd3, make_row(-elem_t'(1), -elem_t'(1), -elem_t'(1), -elem_t'(1)));
    send_request(CMD_MUL, 2'd2, make_row(elem_t'(7), ONE_Q, -ONE_Q, SAT_MIN));
    send_request(CMD_LOAD, 2'd1, make_row(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
    send_request(CMD_MUL, 2'd1, make_row(ONE_Q, ONE_Q, ONE_Q, ONE_Q));
  endtask

  task automatic test_random_traffic(int count);
    cmd_t cmd;
    row_t elems;
    for (int i = 0; i < count; i++) begin
      // Now and then reload all of B with small values, then multiply against it.
      if ($urandom_range(99) < 4) begin
        for (int r = 0; r < DIM; r++) begin
          for (int k = 0; k < DIM; k++) begin
            elems[k] = elem_t'($urandom_range(32'h0004_0000)) - elem_t'(32'h0002_0000);
          end
          send_request(CMD_LOAD, ROW_W'(r), elems);
        end
      end
      cmd = ($urandom_range(99) < 20) ? CMD_LOAD : CMD_MUL;
      for (int k = 0; k < DIM; k++) begin
        elems[k] = random_elem();
      end
      send_request(cmd, ROW_W'($urandom_range(DIM - 1)), elems);
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // queue and pipeline fill and in_tready has to drop.
  task automatic test_output_backpressure();
    row_t elems;
    stall_cycles = 200;
    for (int i = 0; i < 24; i++) begin
      for (int k = 0; k < DIM; k++) begin
        elems[k] = random_elem();
      end
      send_request(CMD_MUL, ROW_W'(i % DIM), elems);
    end
  endtask

  initial begin
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        b_rows[i][j] = (i == j) ? ONE_Q : '0;
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 53;
    test_identity_after_reset();
    test_directed_extremes();
    test_random_traffic(100);

    send_idle_pct = 53;
    recv_idle_pct = 7;
    test_random_traffic(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(100);

    in_tvalid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ERROR: run timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/mm4_pkg.sv
rtl/mm4_front.sv
rtl/mm4_back.sv
rtl/matrix_4x4_multiply.sv
sim/matrix_4x4_multiply_tb.sv
